FILE: rtl/core/mips_overlay_relocator_assert.svh
// Assertion macros shared by the overlay relocator RTL.
// Included by the modules that check their own control logic; no other dependencies.
`ifndef MIPS_OVERLAY_RELOCATOR_ASSERT_SVH
`define MIPS_OVERLAY_RELOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define MOR_ASSERT_IMPL(lbl, clk, rst_n, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error("relocator assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MOR_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("relocator assertion failed");
`else
`define MOR_ASSERT_IMPL(lbl, clk, rst_n, trig, cons)
`define MOR_ASSERT_NEXT(lbl, clk, rst_n, trig, cons)
`endif

`endif

FILE: rtl/core/mor_pkg.sv
// Types and constants of the overlay relocator.
// Used by every module of the block; depends on nothing.
package mor_pkg;

	localparam int unsigned NUM_REGS  = 32;
	localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

	// Relocation types held in entry bits 29:24.
	localparam logic [5:0] RTYPE_WORD32 = 6'd2;
	localparam logic [5:0] RTYPE_JUMP26 = 6'd4;
	localparam logic [5:0] RTYPE_HI16   = 6'd5;
	localparam logic [5:0] RTYPE_LO16   = 6'd6;

	// Section ids held in entry bits 31:30.
	localparam logic [1:0] SEC_NONE   = 2'd0;
	localparam logic [1:0] SEC_TEXT   = 2'd1;
	localparam logic [1:0] SEC_DATA   = 2'd2;
	localparam logic [1:0] SEC_RODATA = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_LOAD_ADDR = 2'd0;
	localparam logic [1:0] CFG_LINK_ADDR = 2'd1;
	localparam logic [1:0] CFG_TEXT_SIZE = 2'd2;
	localparam logic [1:0] CFG_DATA_SIZE = 2'd3;

	localparam logic [31:0] SEGMENT_MASK  = 32'h0F00_0000;
	localparam logic [31:0] OPCODE_MASK   = 32'hFC00_0000;
	localparam logic [31:0] JUMP_ADDR_MASK = 32'h0FFF_FFFF;
	localparam logic [31:0] UPPER_MASK    = 32'hFFFF_0000;
	localparam logic [31:0] KSEG0_BIT     = 32'h8000_0000;
	localparam logic [31:0] JUMP_IDX_MASK = 32'h03FF_FFFF;

	// One recorded LUI, indexed by its register number.
	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] saved;
		logic [31:0] current;
	} hi_entry_t;

	typedef struct packed {
		logic                 en;
		logic [REG_IDX_W-1:0] idx;
		hi_entry_t            data;
	} hi_write_t;

	typedef struct packed {
		logic        hi_we;
		logic [31:0] hi_addr;
		logic [31:0] hi_data;
		logic        t_we;
		logic [31:0] t_addr;
		logic [31:0] t_data;
	} patch_result_t;

endpackage

FILE: rtl/core/mor_hi_table.sv
// LUI record table: one synchronous 32-entry memory with registered read data.
// A write and a read of the same entry at one edge are forwarded. Uses mor_pkg.
`include "mips_overlay_relocator_assert.svh"

module mor_hi_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [mor_pkg::REG_IDX_W-1:0]   rd_idx,
	input  mor_pkg::hi_write_t              wr,
	output mor_pkg::hi_entry_t              rd_data
);
	import mor_pkg::*;

	hi_entry_t mem_q [NUM_REGS];
	hi_entry_t rd_q;
	hi_entry_t byp_q;
	logic      fwd_q;
	logic      same_entry;

	assign same_entry = wr.en && (wr.idx == rd_idx);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			rd_q  <= mem_q[rd_idx];
			byp_q <= wr.data;
		end
	end

	// The memory returns the old contents when the entry is written at the read edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= same_entry;
		end
	end

	assign rd_data = fwd_q ? byp_q : rd_q;

	`MOR_ASSERT_NEXT(a_fwd_set, clk, arst_n, rd_en && same_entry, fwd_q)
	`MOR_ASSERT_NEXT(a_fwd_clear, clk, arst_n, rd_en && !same_entry, !fwd_q)
	`MOR_ASSERT_NEXT(a_fwd_hold, clk, arst_n, !rd_en, $stable(fwd_q))

endmodule

FILE: rtl/core/mor_patch_unit.sv
// Patch logic of the relocator: decodes one entry and computes the rewritten words
// and the table update from the recorded LUI. Uses mor_pkg.
module mor_patch_unit (
	input  logic [5:0]             rtype,
	input  logic [31:0]            base,
	input  logic [23:0]            offset,
	input  logic [31:0]            word,
	input  mor_pkg::hi_entry_t     hi_rd,
	input  logic [31:0]            load_addr,
	input  logic [31:0]            link_addr,
	output mor_pkg::patch_result_t res,
	output mor_pkg::hi_write_t     hi_wr
);
	import mor_pkg::*;

	logic [31:0] target_addr;
	logic [31:0] word_reb;
	logic [31:0] jump_tgt;
	logic [31:0] jump_reb;
	logic [31:0] lo_sext;
	logic [31:0] chk;
	logic [31:0] rel;
	logic [15:0] new_upper;
	logic [31:0] new_hi;

	assign target_addr = base + {8'd0, offset};
	assign word_reb    = word - link_addr + load_addr;
	assign jump_tgt    = ((word & JUMP_IDX_MASK) << 2) | KSEG0_BIT;
	assign jump_reb    = jump_tgt - link_addr + load_addr;
	assign lo_sext     = {{16{word[15]}}, word[15:0]};
	assign chk         = {hi_rd.current[15:0], 16'd0} + lo_sext;
	assign rel         = {hi_rd.saved[15:0], 16'd0} + lo_sext - link_addr + load_addr;
	// A negative low half borrows from the high half, so add it back.
	assign new_upper   = rel[31:16] + {15'd0, rel[15]};
	assign new_hi      = (hi_rd.current & UPPER_MASK) | {16'd0, new_upper};

	always_comb begin
		res         = '0;
		res.t_addr  = target_addr;
		res.t_data  = word;
		hi_wr       = '0;
		hi_wr.idx   = word[20:16];
		hi_wr.data  = '{addr: target_addr, saved: word, current: word};
		unique case (rtype)
			RTYPE_WORD32: begin
				if ((word & SEGMENT_MASK) == '0) begin
					res.t_we   = 1'b1;
					res.t_data = word_reb;
				end
			end
			RTYPE_JUMP26: begin
				res.t_we   = 1'b1;
				res.t_data = (word & OPCODE_MASK) | ((jump_reb & JUMP_ADDR_MASK) >> 2);
			end
			RTYPE_HI16: begin
				hi_wr.en = 1'b1;
			end
			RTYPE_LO16: begin
				hi_wr.idx  = word[25:21];
				hi_wr.data = '{addr: hi_rd.addr, saved: hi_rd.saved, current: new_hi};
				if ((chk & SEGMENT_MASK) == '0) begin
					hi_wr.en    = 1'b1;
					res.hi_we   = 1'b1;
					res.hi_addr = hi_rd.addr;
					res.hi_data = new_hi;
					res.t_we    = 1'b1;
					res.t_data  = (word & UPPER_MASK) | {16'd0, rel[15:0]};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/core/mips_overlay_relocator.sv
// Overlay relocator: applies relocation entries of an overlay loaded away from its
// link address. Depends on mor_pkg, mor_hi_table, mor_patch_unit and the assertion header.
//
// Usage: relocation entries stream in on the input channel (in_valid, in_stall)
// together with the word currently stored at each target. Every accepted
// transaction gives exactly one result transaction on the output channel
// (out_valid, out_stall) with the target rewrite and, for a LO16 entry that passes its
// segment check, the rewrite of its paired LUI word. table_done echoes final_entry.
// An accepted entry is registered in the first stage, its result in the output register,
// held with out_valid until taken. One transaction is taken every cycle unless the output
// stalls; the LUI table is a single memory read at acceptance and written back as the
// entry leaves the first stage, with forwarding if consecutive entries use one register.
// When the receiver stalls, the result is held in the output register and one
// more transaction can still be taken into the first stage; further input is
// stalled until the output is taken.
// Reset empties the pipeline and loads the address registers with their defaults; the LUI
// table is not cleared and must be filled by HI16 entries. Configuration is written via
// cfg_write, cfg_index and cfg_data; the user must do so only while idle (not enforced).
`include "mips_overlay_relocator_assert.svh"

module mips_overlay_relocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] reloc_entry,
	input  logic [31:0] target_word,
	input  logic        final_entry,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hi_write_enable,
	output logic [31:0] hi_write_address,
	output logic [31:0] hi_write_data,
	output logic        target_write_enable,
	output logic [31:0] target_write_address,
	output logic [31:0] target_write_data,
	output logic        table_done
);
	import mor_pkg::*;

	logic [31:0] load_addr_q;
	logic [31:0] link_addr_q;
	logic [23:0] text_size_q;
	logic [23:0] data_size_q;

	logic          accept;
	logic          s2_free;
	logic          s1_adv;
	logic [31:0]   data_base;
	logic [31:0]   base_in;

	logic          s1_valid_q;
	logic [5:0]    rtype_s1;
	logic [31:0]   base_s1;
	logic [23:0]   offset_s1;
	logic [31:0]   word_s1;
	logic          final_s1;

	hi_entry_t     hi_rd;
	hi_write_t     patch_wr;
	hi_write_t     table_wr;
	patch_result_t res;

	logic          out_valid_q;
	patch_result_t res_s2;
	logic          final_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_addr_q <= 32'h8000_0000;
			link_addr_q <= 32'h8080_0000;
			text_size_q <= '0;
			data_size_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_LOAD_ADDR: load_addr_q <= cfg_data;
				CFG_LINK_ADDR: link_addr_q <= cfg_data;
				CFG_TEXT_SIZE: text_size_q <= cfg_data[23:0];
				CFG_DATA_SIZE: data_size_q <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	assign s2_free  = !out_valid_q || !out_stall;
	assign s1_adv   = s1_valid_q && s2_free;
	assign in_stall = s1_valid_q && !s2_free;
	assign accept   = in_valid && !in_stall;

	// The section base is settled before the first stage so that stage adds only the offset.
	assign data_base = load_addr_q + {8'd0, text_size_q};
	always_comb begin
		unique case (reloc_entry[31:30])
			SEC_NONE:   base_in = '0;
			SEC_TEXT:   base_in = load_addr_q;
			SEC_DATA:   base_in = data_base;
			SEC_RODATA: base_in = data_base + {8'd0, data_size_q};
			default:    base_in = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rtype_s1  <= reloc_entry[29:24];
			base_s1   <= base_in;
			offset_s1 <= reloc_entry[23:0];
			word_s1   <= target_word;
			final_s1  <= final_entry;
		end
	end

	always_comb begin
		table_wr    = patch_wr;
		table_wr.en = patch_wr.en && s1_adv;
	end

	mor_hi_table u_hi_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (target_word[25:21]),
		.wr      (table_wr),
		.rd_data (hi_rd)
	);

	mor_patch_unit u_patch (
		.rtype     (rtype_s1),
		.base      (base_s1),
		.offset    (offset_s1),
		.word      (word_s1),
		.hi_rd     (hi_rd),
		.load_addr (load_addr_q),
		.link_addr (link_addr_q),
		.res       (res),
		.hi_wr     (patch_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2   <= res;
			final_s2 <= final_s1;
		end
	end

	assign out_valid            = out_valid_q;
	assign hi_write_enable      = res_s2.hi_we;
	assign hi_write_address     = res_s2.hi_addr;
	assign hi_write_data        = res_s2.hi_data;
	assign target_write_enable  = res_s2.t_we;
	assign target_write_address = res_s2.t_addr;
	assign target_write_data    = res_s2.t_data;
	assign table_done           = final_s2;

	`MOR_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, s1_valid_q && out_valid_q && out_stall)
	`MOR_ASSERT_NEXT(a_accept_fills, clk, arst_n, accept, s1_valid_q)
	`MOR_ASSERT_NEXT(a_adv_fills_out, clk, arst_n, s1_adv, out_valid_q)
	`MOR_ASSERT_IMPL(a_hi_with_target, clk, arst_n, out_valid_q && hi_write_enable,
		target_write_enable)

endmodule
